// ===== design/uvst_pkg.sv =====
// Package with the shared sizes, operation codes and sequencer states of the value set table.
`timescale 1ns / 1ps

package uvst_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 2;
    localparam int CFG_W    = 5;
    localparam int CFG_RESET = 16;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } seq_state_t;

endpackage

// ===== design/uvst_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module uvst_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/unique_value_set_table.sv =====
// Top level of the value set table: request sequencer, entry memory and result register.
//
//   channel   direction  handshake              payload
//   in        receive    in_valid / in_stall    op, value, index
//   out       send       out_valid / out_stall  ok, found, removed_value, count_after
//   cfg       receive    cfg_we                 cfg_wdata (capacity_in_use)
//
// One request at a time. Insert and lookup end the scan early on a match; a failed
// remove or unused code 3 reads no entry. The entries sit in one RAM with one read and
// one write port, one entry a cycle. Reset clears the count, the sequencer and the
// valid flags and loads the reset capacity; entries above the count are never read.
// A finished result waits in its state until the output register is free; the output
// register holds a result under out_stall while the next request is already accepted.
`timescale 1ns / 1ps

module unique_value_set_table
    import uvst_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          op,
    input  logic signed [DATA_W-1:0] value,
    input  logic [IDX_W-1:0]         index,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     ok,
    output logic                     found,
    output logic signed [DATA_W-1:0] removed_value,
    output logic [CNT_W-1:0]         count_after,
    input  logic                     cfg_we,
    input  logic [CFG_W-1:0]         cfg_wdata
);

    seq_state_t state_reg, state_next;

    logic [CFG_W-1:0]  capacity_in_use_reg;
    logic [CNT_W-1:0]  valid_count_reg, valid_count_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [IDX_W-1:0]  last_addr_reg, last_addr_next;
    logic              pend_reg, pend_next;
    logic              hit_reg, hit_next;
    logic [DATA_W-1:0] removed_reg, removed_next;

    logic              out_valid_reg, out_valid_next;
    logic              ok_reg, ok_next;
    logic              found_reg, found_next;
    logic [DATA_W-1:0] removed_out_reg, removed_out_next;
    logic [CNT_W-1:0]  count_out_reg, count_out_next;

    logic              accept;
    logic              can_load;
    logic              issue;
    logic              is_search;
    logic              remove_valid;
    logic              insert_ok;
    logic [CNT_W-1:0]  limit;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    uvst_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign can_load = !out_valid_reg || !out_stall;
    assign issue    = (ptr_reg < valid_count_reg);
    assign is_search = (op_reg == OP_INSERT) || (op_reg == OP_LOOKUP);

    // The limit in force saturates at the built depth.
    assign limit = (32'(capacity_in_use_reg) < 32'(CAPACITY)) ?
                   CNT_W'(capacity_in_use_reg) : CNT_W'(CAPACITY);

    assign remove_valid = (CNT_W'(index_reg) < valid_count_reg);
    assign insert_ok    = !hit_reg && (valid_count_reg < limit);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (pend_reg && is_search && (mem_rdata == value_reg))
                begin
                    state_next = S_FINISH;
                end
                else if (!issue && !pend_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        op_next          = op_reg;
        value_next       = value_reg;
        index_next       = index_reg;
        ptr_next         = ptr_reg;
        last_addr_next   = last_addr_reg;
        pend_next        = 1'b0;
        hit_next         = hit_reg;
        removed_next     = removed_reg;
        valid_count_next = valid_count_reg;
        out_valid_next   = out_valid_reg && out_stall;
        ok_next          = ok_reg;
        found_next       = found_reg;
        removed_out_next = removed_out_reg;
        count_out_next   = count_out_reg;
        mem_we           = 1'b0;
        mem_waddr        = ptr_reg[IDX_W-1:0];
        mem_wdata        = value_reg;
        mem_re           = 1'b0;
        mem_raddr        = ptr_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = op;
                    value_next   = $unsigned(value);
                    index_next   = index;
                    hit_next     = 1'b0;
                    removed_next = '0;
                    // A scan that starts at the count ends at once.
                    if ((op == OP_INSERT) || (op == OP_LOOKUP))
                    begin
                        ptr_next = '0;
                    end
                    else if ((op == OP_REMOVE) && (CNT_W'(index) < valid_count_reg))
                    begin
                        ptr_next = CNT_W'(index);
                    end
                    else
                    begin
                        ptr_next = valid_count_reg;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    mem_re         = 1'b1;
                    ptr_next       = ptr_reg + CNT_W'(1);
                    last_addr_next = ptr_reg[IDX_W-1:0];
                    pend_next      = 1'b1;
                end
                if (pend_reg)
                begin
                    if (is_search)
                    begin
                        if (mem_rdata == value_reg)
                        begin
                            hit_next = 1'b1;
                        end
                    end
                    else if (last_addr_reg == index_reg)
                    begin
                        removed_next = mem_rdata;
                    end
                    else
                    begin
                        // Later entries move down one slot.
                        mem_we    = 1'b1;
                        mem_waddr = last_addr_reg - IDX_W'(1);
                        mem_wdata = mem_rdata;
                    end
                end
            end
            S_FINISH:
            begin
                if (can_load)
                begin
                    out_valid_next   = 1'b1;
                    ok_next          = 1'b0;
                    found_next       = 1'b0;
                    removed_out_next = '0;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            found_next = hit_reg;
                            if (insert_ok)
                            begin
                                ok_next          = 1'b1;
                                mem_we           = 1'b1;
                                mem_waddr        = valid_count_reg[IDX_W-1:0];
                                mem_wdata        = value_reg;
                                valid_count_next = valid_count_reg + CNT_W'(1);
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (remove_valid)
                            begin
                                ok_next          = 1'b1;
                                removed_out_next = removed_reg;
                                valid_count_next = valid_count_reg - CNT_W'(1);
                            end
                        end
                        OP_LOOKUP:
                        begin
                            found_next = hit_reg;
                            ok_next    = hit_reg;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                    count_out_next = valid_count_next;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            valid_count_reg     <= '0;
            capacity_in_use_reg <= CFG_W'(CFG_RESET);
            out_valid_reg       <= 1'b0;
            pend_reg            <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            valid_count_reg <= valid_count_next;
            out_valid_reg   <= out_valid_next;
            pend_reg        <= pend_next;
            if (cfg_we)
            begin
                capacity_in_use_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        value_reg       <= value_next;
        index_reg       <= index_next;
        ptr_reg         <= ptr_next;
        last_addr_reg   <= last_addr_next;
        hit_reg         <= hit_next;
        removed_reg     <= removed_next;
        ok_reg          <= ok_next;
        found_reg       <= found_next;
        removed_out_reg <= removed_out_next;
        count_out_reg   <= count_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign ok            = ok_reg;
    assign found         = found_reg;
    assign removed_value = $signed(removed_out_reg);
    assign count_after   = count_out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds the table depth");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (count_out_reg == valid_count_reg))
        else $error("reported count differs from the table count");

    a_removed_only_on_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (removed_out_reg != '0)) |-> (ok_reg && !found_reg))
        else $error("removed value reported without a successful removal");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != S_IDLE))
        else $error("entry memory written while idle");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_FINISH) |=> (valid_count_reg == $past(valid_count_reg)))
        else $error("entry count changed outside the finishing step");
`endif

endmodule

// ===== tb/unique_value_set_table_tb.sv =====
// Testbench for the value set table: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module unique_value_set_table_tb;
    import uvst_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int POOL_SIZE   = 24;

    typedef struct packed {
        logic                     ok;
        logic                     found;
        logic signed [DATA_W-1:0] removed;
        logic [CNT_W-1:0]         count;
    } set_result_t;

    typedef struct {
        logic [CFG_W-1:0] capacity;
        int               remove_pct;
        int               requests;
        bit               idle_on;
        bit               long_hold;
    } phase_t;

    class set_scoreboard;
        logic signed [DATA_W-1:0] slots[CAPACITY];
        int unsigned              held;
        logic [CFG_W-1:0]         capacity;
        set_result_t              pending_results[$];
        int                       errors;

        function new();
            held     = 0;
            capacity = CFG_W'(CFG_RESET);
            errors   = 0;
        endfunction

        function bit contains(logic signed [DATA_W-1:0] v);
            for (int i = 0; i < held; i++)
                if (slots[i] == v)
                    return 1'b1;
            return 1'b0;
        endfunction

        function void note_request(logic [OP_W-1:0] code, logic signed [DATA_W-1:0] v,
                                   logic [IDX_W-1:0] at);
            set_result_t r;
            int unsigned limit;
            limit     = (capacity < CAPACITY) ? capacity : CAPACITY;
            r.ok      = 1'b0;
            r.found   = 1'b0;
            r.removed = '0;
            case (code)
                OP_INSERT:
                begin
                    r.found = contains(v);
                    if (!r.found && held < limit)
                    begin
                        slots[held] = v;
                        held++;
                        r.ok = 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (at < held)
                    begin
                        r.removed = slots[at];
                        for (int j = at; j + 1 < held; j++)
                            slots[j] = slots[j + 1];
                        held--;
                        r.ok = 1'b1;
                    end
                end
                OP_LOOKUP:
                begin
                    r.found = contains(v);
                    r.ok    = r.found;
                end
                default:
                begin
                end
            endcase
            r.count = CNT_W'(held);
            pending_results.push_back(r);
        endfunction

        function void check_result(set_result_t got);
            set_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding", $time);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.ok !== want.ok)
            begin
                $display("%0t: ok expected %0d, got %0d", $time, want.ok, got.ok);
                errors++;
            end
            if (got.found !== want.found)
            begin
                $display("%0t: found expected %0d, got %0d", $time, want.found, got.found);
                errors++;
            end
            if (got.removed !== want.removed)
            begin
                $display("%0t: removed_value expected %0d, got %0d", $time, want.removed,
                         got.removed);
                errors++;
            end
            if (got.count !== want.count)
            begin
                $display("%0t: count_after expected %0d, got %0d", $time, want.count,
                         got.count);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;
    logic                     out_valid;
    logic                     out_stall;
    logic                     ok;
    logic                     found;
    logic signed [DATA_W-1:0] removed_value;
    logic [CNT_W-1:0]         count_after;
    logic                     cfg_we;
    logic [CFG_W-1:0]         cfg_wdata;

    set_scoreboard            sb = new();
    logic signed [DATA_W-1:0] value_pool[POOL_SIZE];
    bit                       idling;
    bit                       long_hold_pending;

    unique_value_set_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .value         (value),
        .index         (index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ok            (ok),
        .found         (found),
        .removed_value (removed_value),
        .count_after   (count_after),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({ok, found, removed_value, count_after});
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Receiver: random stalls, plus one long hold-off that lets the block back up.
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (idling && $urandom_range(0, 99) < 25)
            begin
                stall_left = pick_gap() - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic pause_sender(int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic send_request(logic [OP_W-1:0] code, logic signed [DATA_W-1:0] v,
                                logic [IDX_W-1:0] at);
        @(negedge clk);
        in_valid <= 1'b1;
        op       <= code;
        value    <= v;
        index    <= at;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(code, v, at);
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] cap);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        sb.capacity = cap;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 6)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(int remove_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < remove_pct)
            return OP_REMOVE;
        if (r < remove_pct + 30)
            return OP_LOOKUP;
        if (r < remove_pct + 35)
            return OP_UNUSED;
        return OP_INSERT;
    endfunction

    task automatic run_phase(phase_t ph);
        logic [OP_W-1:0]  code;
        logic [IDX_W-1:0] at;
        write_capacity(ph.capacity);
        idling = ph.idle_on;
        if (ph.long_hold)
            long_hold_pending = 1'b1;
        for (int n = 0; n < ph.requests; n++)
        begin
            if (idling && $urandom_range(0, 99) < 30)
                pause_sender(pick_gap());
            code = pick_op(ph.remove_pct);
            // Mostly aim removals at occupied slots so the shift path gets exercised.
            if (sb.held > 0 && $urandom_range(0, 3) != 0)
                at = IDX_W'($urandom_range(0, sb.held - 1));
            else
                at = IDX_W'($urandom_range(0, CAPACITY - 1));
            send_request(code, pick_value(), at);
        end
        pause_sender(1);
        wait_drained();
    endtask

    initial
    begin
        phase_t phases[8];
        logic signed [DATA_W-1:0] int_min;
        logic signed [DATA_W-1:0] int_max;

        int_min           = {1'b1, {(DATA_W-1){1'b0}}};
        int_max           = {1'b0, {(DATA_W-1){1'b1}}};
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        op                = OP_INSERT;
        value             = '0;
        index             = '0;
        out_stall         = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        idling            = 1'b1;
        long_hold_pending = 1'b0;

        value_pool[0] = 0;
        value_pool[1] = 1;
        value_pool[2] = -1;
        value_pool[3] = int_min;
        value_pool[4] = int_max;
        value_pool[5] = int_min + 1;
        value_pool[6] = int_max - 1;
        for (int i = 7; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        phases[0] = '{5'd31, 15, 130, 1'b1, 1'b0};
        phases[1] = '{5'd3,  30,  90, 1'b1, 1'b0};
        phases[2] = '{5'd16, 25, 130, 1'b0, 1'b1};
        phases[3] = '{5'd0,  25,  60, 1'b1, 1'b0};
        phases[4] = '{5'd7,  25, 110, 1'b1, 1'b0};
        phases[5] = '{5'd1,  25,  60, 1'b1, 1'b0};
        phases[6] = '{5'd16, 45, 100, 1'b1, 1'b0};
        phases[7] = '{5'd20, 20,  90, 1'b1, 1'b0};

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, starting from the reset capacity.
        send_request(OP_LOOKUP, 5, 0);
        send_request(OP_REMOVE, 0, 0);
        send_request(OP_REMOVE, 0, 15);
        send_request(OP_INSERT, int_min, 0);
        send_request(OP_INSERT, int_max, 0);
        send_request(OP_INSERT, 0, 0);
        send_request(OP_INSERT, -1, 0);
        send_request(OP_INSERT, int_min, 0);
        send_request(OP_LOOKUP, int_max, 0);
        send_request(OP_LOOKUP, 1, 0);
        send_request(OP_UNUSED, -1, 15);
        send_request(OP_REMOVE, 0, 1);
        send_request(OP_REMOVE, 0, 3);
        send_request(OP_REMOVE, 0, 2);
        pause_sender(1);
        wait_drained();

        // Zero capacity while two entries are still held.
        write_capacity(5'd0);
        send_request(OP_INSERT, 7, 0);
        send_request(OP_LOOKUP, 0, 0);
        send_request(OP_REMOVE, 0, 0);
        pause_sender(1);
        wait_drained();

        write_capacity(5'd1);
        send_request(OP_INSERT, 9, 0);
        send_request(OP_REMOVE, 0, 0);
        send_request(OP_INSERT, 9, 0);
        send_request(OP_INSERT, 10, 0);
        pause_sender(1);
        wait_drained();

        foreach (phases[p])
            run_phase(phases[p]);

        idling = 1'b0;
        wait_drained();
        repeat (30) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== unique_value_set_table.f =====
design/uvst_pkg.sv
design/uvst_ram.sv
design/unique_value_set_table.sv
tb/unique_value_set_table_tb.sv
